[src/sitda_pkg.sv]
package sitda_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned NDIGITS  = 10;
    localparam int unsigned BCD_W    = 4 * NDIGITS;
    localparam int unsigned DIGIT_IW = 4;
    localparam int unsigned CNT_W    = 5;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    typedef logic [BCD_W-1:0] bcd_t;

    // Add three to every BCD digit of five or more, ahead of the shift.
    function automatic bcd_t bcd_adjust(input bcd_t x);
        bcd_t r;
        logic [3:0] d;
        r = x;
        for (int i = 0; i < NDIGITS; i++)
        begin
            d = x[4*i +: 4];
            r[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
        return r;
    endfunction

    // Index of the most significant nonzero digit; zero gives index 0.
    function automatic logic [DIGIT_IW-1:0] top_digit(input bcd_t x);
        logic [DIGIT_IW-1:0] r;
        r = '0;
        for (int i = 0; i < NDIGITS; i++)
        begin
            if (x[4*i +: 4] != 4'd0)
            begin
                r = DIGIT_IW'(i);
            end
        end
        return r;
    endfunction

endpackage

[src/signed_int_to_decimal_ascii.sv]
// Signed 32-bit integer to decimal ASCII text.
//
// Input channel: value with in_valid / in_stall. A transfer takes place at a
// rising edge with in_valid high and in_stall low. in_stall is high while a
// number is being converted or its characters are being emitted.
// Output channel: out_char and is_last with out_valid / out_stall. One
// transfer per character, most significant first; a negative number starts
// with '-'. is_last marks the final digit.
//
// The magnitude goes through a shift-and-add-3 BCD converter that does one
// bit per cycle, then a scan state finds the leading digit, and the
// characters follow at one per cycle when the receiver takes them at once.
// An item has 1 to 11 characters. in_stall stays high through conversion,
// scan and emission, so the next input transfer waits until the item's last
// character has been loaded into the output register.
//
// While out_stall is high the character in the output register holds and
// emission waits. A new input is taken as soon as the last character sits in
// the output register, even if it is still stalled there.
// Reset empties the output register and returns the sequencer to idle.
module signed_int_to_decimal_ascii
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [sitda_pkg::VALUE_W-1:0] value,
    input  logic                          in_valid,
    output logic                          in_stall,
    output logic [sitda_pkg::CHAR_W-1:0]  out_char,
    output logic                          is_last,
    output logic                          out_valid,
    input  logic                          out_stall
);
    import sitda_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [VALUE_W-1:0]      bin_reg, bin_next;
    bcd_t                    bcd_reg, bcd_next;
    logic                    sign_reg, sign_next;
    logic [DIGIT_IW-1:0]     idx_reg, idx_next;
    logic                    out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]       out_char_reg, out_char_next;
    logic                    is_last_reg, is_last_next;

    logic                    in_xfer;
    logic                    out_free;
    bcd_t                    bcd_adj;
    logic [3:0]              digit;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign is_last   = is_last_reg;

    assign bcd_adj = bcd_adjust(bcd_reg);
    assign digit   = bcd_reg[4*idx_reg +: 4];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        sign_next      = sign_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        is_last_next   = is_last_reg;

        // Drop the held character once the receiver takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    sign_next  = value[VALUE_W-1];
                    bin_next   = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value))
                                                  : VALUE_W'(value);
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // Adjust, then shift the next magnitude bit into the BCD word.
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                idx_next   = top_digit(bcd_reg);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        out_char_next = CHAR_MINUS;
                        is_last_next  = 1'b0;
                        sign_next     = 1'b0;
                    end
                    else
                    begin
                        out_char_next = CHAR_ZERO + CHAR_W'(digit);
                        is_last_next  = (idx_reg == '0);
                        if (idx_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg - DIGIT_IW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        sign_reg     <= sign_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        is_last_reg  <= is_last_next;
    end

    // An accepted input always starts a fresh conversion pass.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_CONV) && (cnt_reg == '0))
        else $error("conversion did not start after input transfer");

    // A minus sign is never the final character.
    a_minus: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_char_reg == CHAR_MINUS) |-> !is_last_reg)
        else $error("minus sign flagged as last character");

    // The digit pointer stays inside the BCD word while emitting.
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (idx_reg < DIGIT_IW'(NDIGITS)))
        else $error("digit index out of range");

    // Leaving emission means the last digit was just loaded.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next == ST_IDLE) |=>
            (out_valid_reg && is_last_reg))
        else $error("emission ended without a last character");

endmodule
